// ===== hdl/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and codes for the piecewise-linear membership block.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

  localparam int CNT_W = 5;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic valid;
    logic done;
    logic exact;
    logic have_lo;
    logic have_hi;
  } plm_flags_t;

endpackage

`default_nettype wire

// ===== hdl/piecewise_linear_membership.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_membership
// Breakpoint table held in a chain of cells; an evaluate item walks the chain
// one cell per cycle, then a multiply and a bit-serial divide interpolate.
//
//   channel  ports                                      transfer
//   in       start, busy, in_action .. in_sample_x      start high, busy low
//   out      out_valid, out_membership_value            out_valid high
//   cfg      cfg_valid, cfg_ready, cfg_point_count      cfg_valid, cfg_ready
//
// A load item writes its table slot directly. An evaluate item walks the
// cell chain; a result that needs no interpolation is then output directly,
// otherwise it goes through the multiply and the bit-serial divider.
// Reset clears the control state and the point count; the table holds
// garbage until written. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_membership #(
  parameter int MAX_POINTS = 16,
  parameter int X_WIDTH    = 16,
  parameter int Y_WIDTH    = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_action,
  input  wire [$clog2(MAX_POINTS)-1:0]         in_point_index,
  input  wire signed [X_WIDTH-1:0]             in_point_x,
  input  wire [Y_WIDTH-1:0]                    in_point_y,
  input  wire signed [X_WIDTH-1:0]             in_sample_x,
  output logic                                 out_valid,
  output logic [Y_WIDTH-1:0]                   out_membership_value,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [plm_pkg::CNT_W-1:0]             cfg_point_count
);
  import plm_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = X_WIDTH + 1 + Y_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_MULT, S_DIV} state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [CW-1:0]            n;
  logic [CW+CNT_W-1:0]      cnt_ext;
  logic                     accept, load_en;

  plm_flags_t               head_f;
  plm_flags_t               ch_f       [MAX_POINTS+1];
  logic signed [X_WIDTH-1:0] ch_s      [MAX_POINTS+1];
  logic signed [X_WIDTH-1:0] ch_lo_x   [MAX_POINTS+1];
  logic [Y_WIDTH-1:0]        ch_lo_y   [MAX_POINTS+1];
  logic signed [X_WIDTH-1:0] ch_hi_x   [MAX_POINTS+1];
  logic [Y_WIDTH-1:0]        ch_hi_y   [MAX_POINTS+1];
  logic signed [X_WIDTH-1:0] ch_fst_x  [MAX_POINTS+1];
  logic [Y_WIDTH-1:0]        ch_fst_y  [MAX_POINTS+1];
  logic signed [X_WIDTH-1:0] ch_lst_x  [MAX_POINTS+1];
  logic [Y_WIDTH-1:0]        ch_lst_y  [MAX_POINTS+1];

  plm_flags_t                tf;
  logic signed [X_WIDTH-1:0] ts, xl, xh;
  logic [Y_WIDTH-1:0]        yl, yh, direct_y;
  logic                      direct;
  logic [X_WIDTH:0]          dx, dxs;

  logic [Y_WIDTH-1:0]        yl_r, mag_r;
  logic                      up_r;
  logic [X_WIDTH:0]          dx_r, dxs_r;
  logic [PW-1:0]             prod_r;
  logic                      div_go_r, div_done;
  logic [Y_WIDTH-1:0]        quot;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign load_en   = accept && (in_action == ACT_LOAD);

  assign cnt_ext = (CW+CNT_W)'(count_r);
  assign n       = (cnt_ext > (CW+CNT_W)'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cnt_ext);

  always_comb begin
    head_f       = '0;
    head_f.valid = accept && (in_action == ACT_EVAL);
  end

  assign ch_f[0]     = head_f;
  assign ch_s[0]     = in_sample_x;
  assign ch_lo_x[0]  = '0;
  assign ch_lo_y[0]  = '0;
  assign ch_hi_x[0]  = '0;
  assign ch_hi_y[0]  = '0;
  assign ch_fst_x[0] = '0;
  assign ch_fst_y[0] = '0;
  assign ch_lst_x[0] = '0;
  assign ch_lst_y[0] = '0;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    plm_cell #(
      .IDX(i), .MAX_POINTS(MAX_POINTS), .X_WIDTH(X_WIDTH), .Y_WIDTH(Y_WIDTH),
      .IW(IW), .CW(CW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .wr_en(load_en), .wr_index(in_point_index), .wr_x(in_point_x), .wr_y(in_point_y),
      .n(n),
      .flags_in(ch_f[i]), .s_in(ch_s[i]),
      .lo_x_in(ch_lo_x[i]), .lo_y_in(ch_lo_y[i]),
      .hi_x_in(ch_hi_x[i]), .hi_y_in(ch_hi_y[i]),
      .first_x_in(ch_fst_x[i]), .first_y_in(ch_fst_y[i]),
      .last_x_in(ch_lst_x[i]), .last_y_in(ch_lst_y[i]),
      .flags_out(ch_f[i+1]), .s_out(ch_s[i+1]),
      .lo_x_out(ch_lo_x[i+1]), .lo_y_out(ch_lo_y[i+1]),
      .hi_x_out(ch_hi_x[i+1]), .hi_y_out(ch_hi_y[i+1]),
      .first_x_out(ch_fst_x[i+1]), .first_y_out(ch_fst_y[i+1]),
      .last_x_out(ch_lst_x[i+1]), .last_y_out(ch_lst_y[i+1])
    );
  end

  assign tf  = ch_f[MAX_POINTS];
  assign ts  = ch_s[MAX_POINTS];
  assign xl  = tf.have_lo ? ch_lo_x[MAX_POINTS] : ch_fst_x[MAX_POINTS];
  assign yl  = tf.have_lo ? ch_lo_y[MAX_POINTS] : ch_fst_y[MAX_POINTS];
  assign xh  = tf.have_hi ? ch_hi_x[MAX_POINTS] : ch_lst_x[MAX_POINTS];
  assign yh  = tf.have_hi ? ch_hi_y[MAX_POINTS] : ch_lst_y[MAX_POINTS];
  assign dx  = {xh[X_WIDTH-1], xh} - {xl[X_WIDTH-1], xl};
  assign dxs = {ts[X_WIDTH-1], ts} - {xl[X_WIDTH-1], xl};

  always_comb begin
    direct   = 1'b1;
    direct_y = yl;
    if (n == '0) begin
      direct_y = '0;
    end else if (ts <= ch_fst_x[MAX_POINTS]) begin
      direct_y = ch_fst_y[MAX_POINTS];
    end else if (ts >= ch_lst_x[MAX_POINTS]) begin
      direct_y = ch_lst_y[MAX_POINTS];
    end else if (tf.exact) begin
      direct_y = ch_lo_y[MAX_POINTS];
    end else if (xh <= xl || ts <= xl) begin
      direct_y = yl;
    end else begin
      direct = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      count_r   <= '0;
      div_go_r  <= 1'b0;
    end else begin
      out_valid <= (state_r == S_SEARCH && tf.valid && direct) ||
                   (state_r == S_DIV && div_done);
      div_go_r  <= (state_r == S_MULT);
      if (cfg_valid) begin
        count_r <= cfg_point_count;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_action == ACT_EVAL) begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tf.valid) begin
            if (direct) begin
              out_membership_value <= direct_y;
              state_r              <= S_IDLE;
            end else begin
              yl_r    <= yl;
              up_r    <= (yh >= yl);
              mag_r   <= (yh >= yl) ? yh - yl : yl - yh;
              dx_r    <= dx;
              dxs_r   <= dxs;
              state_r <= S_MULT;
            end
          end
        end
        S_MULT: begin
          prod_r   <= PW'(mag_r) * PW'(dxs_r);
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            out_membership_value <= up_r ? yl_r + quot : yl_r - quot;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  plm_div #(
    .X_WIDTH(X_WIDTH), .Y_WIDTH(Y_WIDTH)
  ) u_div (
    .clk(clk), .rst_n(rst_n),
    .go(div_go_r),
    .num_hi(prod_r[PW-1:Y_WIDTH]),
    .num_lo(prod_r[Y_WIDTH-1:0]),
    .den(dx_r),
    .done(div_done),
    .quot(quot)
  );

endmodule

`default_nettype wire

// ===== hdl/plm_cell.sv =====
// ----------------------------------------------------------------------------
// plm_cell
// One breakpoint slot of the search chain: holds its (x, y) pair and updates
// the search record passing through it.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_cell #(
  parameter int IDX        = 0,
  parameter int MAX_POINTS = 16,
  parameter int X_WIDTH    = 16,
  parameter int Y_WIDTH    = 16,
  parameter int IW         = 4,
  parameter int CW         = 5
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        wr_en,
  input  wire [IW-1:0]               wr_index,
  input  wire signed [X_WIDTH-1:0]   wr_x,
  input  wire [Y_WIDTH-1:0]          wr_y,
  input  wire [CW-1:0]               n,
  input  plm_pkg::plm_flags_t        flags_in,
  input  wire signed [X_WIDTH-1:0]   s_in,
  input  wire signed [X_WIDTH-1:0]   lo_x_in,
  input  wire [Y_WIDTH-1:0]          lo_y_in,
  input  wire signed [X_WIDTH-1:0]   hi_x_in,
  input  wire [Y_WIDTH-1:0]          hi_y_in,
  input  wire signed [X_WIDTH-1:0]   first_x_in,
  input  wire [Y_WIDTH-1:0]          first_y_in,
  input  wire signed [X_WIDTH-1:0]   last_x_in,
  input  wire [Y_WIDTH-1:0]          last_y_in,
  output plm_pkg::plm_flags_t        flags_out,
  output logic signed [X_WIDTH-1:0]  s_out,
  output logic signed [X_WIDTH-1:0]  lo_x_out,
  output logic [Y_WIDTH-1:0]         lo_y_out,
  output logic signed [X_WIDTH-1:0]  hi_x_out,
  output logic [Y_WIDTH-1:0]         hi_y_out,
  output logic signed [X_WIDTH-1:0]  first_x_out,
  output logic [Y_WIDTH-1:0]         first_y_out,
  output logic signed [X_WIDTH-1:0]  last_x_out,
  output logic [Y_WIDTH-1:0]         last_y_out
);
  import plm_pkg::*;

  logic signed [X_WIDTH-1:0] bp_x_r;
  logic [Y_WIDTH-1:0]        bp_y_r;

  plm_flags_t                flags_nxt;
  logic signed [X_WIDTH-1:0] lo_x_nxt, hi_x_nxt, first_x_nxt, last_x_nxt;
  logic [Y_WIDTH-1:0]        lo_y_nxt, hi_y_nxt, first_y_nxt, last_y_nxt;
  logic                      active;

  assign active = flags_in.valid && (CW'(IDX) < n);

  always_comb begin
    flags_nxt   = flags_in;
    lo_x_nxt    = lo_x_in;
    lo_y_nxt    = lo_y_in;
    hi_x_nxt    = hi_x_in;
    hi_y_nxt    = hi_y_in;
    first_x_nxt = first_x_in;
    first_y_nxt = first_y_in;
    last_x_nxt  = last_x_in;
    last_y_nxt  = last_y_in;
    if (active) begin
      if (IDX == 0) begin
        first_x_nxt = bp_x_r;
        first_y_nxt = bp_y_r;
      end
      if (CW'(IDX + 1) == n) begin
        last_x_nxt = bp_x_r;
        last_y_nxt = bp_y_r;
      end
      if (!flags_in.done) begin
        if (bp_x_r == s_in) begin
          flags_nxt.exact = 1'b1;
          flags_nxt.done  = 1'b1;
          lo_y_nxt        = bp_y_r;
        end else if (bp_x_r < s_in) begin
          flags_nxt.have_lo = 1'b1;
          lo_x_nxt          = bp_x_r;
          lo_y_nxt          = bp_y_r;
        end else begin
          flags_nxt.have_hi = 1'b1;
          flags_nxt.done    = 1'b1;
          hi_x_nxt          = bp_x_r;
          hi_y_nxt          = bp_y_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_index == IW'(IDX)) begin
      bp_x_r <= wr_x;
      bp_y_r <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_out <= '0;
    end else begin
      flags_out <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_out       <= s_in;
    lo_x_out    <= lo_x_nxt;
    lo_y_out    <= lo_y_nxt;
    hi_x_out    <= hi_x_nxt;
    hi_y_out    <= hi_y_nxt;
    first_x_out <= first_x_nxt;
    first_y_out <= first_y_nxt;
    last_x_out  <= last_x_nxt;
    last_y_out  <= last_y_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/plm_div.sv =====
// ----------------------------------------------------------------------------
// plm_div
// Restoring divider, one quotient bit per cycle. The upper numerator part
// must already be below the divisor, so the quotient fits Y_WIDTH bits.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_div #(
  parameter int X_WIDTH = 16,
  parameter int Y_WIDTH = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  go,
  input  wire [X_WIDTH:0]      num_hi,
  input  wire [Y_WIDTH-1:0]    num_lo,
  input  wire [X_WIDTH:0]      den,
  output logic                 done,
  output logic [Y_WIDTH-1:0]   quot
);
  import plm_pkg::*;

  localparam int SW = $clog2(Y_WIDTH + 1);

  logic              busy_r;
  logic [SW-1:0]     step_r;
  logic [X_WIDTH:0]  rem_r;
  logic [Y_WIDTH-1:0] sh_r;
  logic [X_WIDTH:0]  den_r;
  logic [X_WIDTH+1:0] trial;
  logic              ge;

  assign trial = {rem_r, sh_r[Y_WIDTH-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quot  = sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= busy_r && !go && (step_r == SW'(Y_WIDTH - 1));
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(Y_WIDTH - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= num_hi;
      sh_r  <= num_lo;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? (X_WIDTH+1)'(trial - {1'b0, den_r}) : trial[X_WIDTH:0];
      sh_r  <= {sh_r[Y_WIDTH-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== dv/piecewise_linear_membership_test.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_membership_test
// Self-checking bench for the breakpoint membership block. Fills the table,
// sweeps the point count through its extremes and evaluates directed and
// random samples against an in-bench interpolation model, with the sender
// idling at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module piecewise_linear_membership_test;
  import plm_pkg::*;

  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_GAP         = 30;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 104;

  class membership_scoreboard;
    bit signed [15:0] knot_x [16];
    bit        [15:0] knot_y [16];
    bit   [CNT_W-1:0] point_count;
    bit        [15:0] expected_memberships [$];
    int               mismatches;

    function void set_point_count(bit [CNT_W-1:0] value);
      point_count = value;
    endfunction

    function bit [15:0] membership_of(bit signed [15:0] s);
      int n, lo, hi, i;
      longint yl, yu, span, offset, mag, q;
      n = (point_count > 16) ? 16 : int'(point_count);
      if (n == 0) return 16'd0;
      if (s <= knot_x[0]) return knot_y[0];
      if (s >= knot_x[n-1]) return knot_y[n-1];
      lo = 0;
      hi = n - 1;
      for (i = 0; i < n; i++) begin
        if (knot_x[i] == s) return knot_y[i];
        if (knot_x[i] < s) lo = i;
        if (knot_x[i] > s) begin
          hi = i;
          break;
        end
      end
      if (knot_x[hi] <= knot_x[lo] || s <= knot_x[lo]) return knot_y[lo];
      yl     = knot_y[lo];
      yu     = knot_y[hi];
      span   = longint'(knot_x[hi]) - longint'(knot_x[lo]);
      offset = longint'(s) - longint'(knot_x[lo]);
      mag    = (yu >= yl) ? yu - yl : yl - yu;
      q      = (mag * offset) / span;
      return (yu >= yl) ? 16'(yl + q) : 16'(yl - q);
    endfunction

    function void note_item(bit action, bit [3:0] slot, bit signed [15:0] px,
                            bit [15:0] py, bit signed [15:0] sx);
      if (action == ACT_LOAD) begin
        knot_x[slot] = px;
        knot_y[slot] = py;
      end else begin
        expected_memberships = {expected_memberships, membership_of(sx)};
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [15:0] got);
      bit [15:0] want;
      if (expected_memberships.size() == 0) begin
        report_mismatch($sformatf("membership_value %h with no evaluate pending", got));
      end else begin
        want = expected_memberships.pop_front();
        if (got !== want)
          report_mismatch($sformatf("membership_value got %h want %h", got, want));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_action;
  logic [3:0]        in_point_index;
  logic signed [15:0] in_point_x;
  logic [15:0]       in_point_y;
  logic signed [15:0] in_sample_x;
  logic              out_valid;
  logic [15:0]       out_membership_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_point_count;

  membership_scoreboard sb = new();
  logic signed [15:0]   slot_x [16];
  int                   idle_pct;
  int                   items_sent;
  int                   quiet_cycles;

  int directed_x [16] = '{-32768, -30000, -20000, -10000, -1000, -1, 0, 1,
                          100, 1000, 5000, 10000, 20000, 30000, 32000, 32767};
  int directed_y [16] = '{0, 65535, 100, 40000, 40000, 65535, 0, 12345,
                          65535, 1, 30000, 30000, 50000, 2, 60000, 65535};
  int phase_counts [PHASES] = '{16, 31, 1, 0, 2, 16, 5, 12, 3, 16, 8, 15};

  piecewise_linear_membership i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_action            (in_action),
    .in_point_index       (in_point_index),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_sample_x          (in_sample_x),
    .out_valid            (out_valid),
    .out_membership_value (out_membership_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_point_count      (cfg_point_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_membership_value);
      if (start && !busy)
        sb.note_item(in_action, in_point_index, in_point_x, in_point_y, in_sample_x);
      if (cfg_valid && cfg_ready) sb.set_point_count(cfg_point_count);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("piecewise_linear_membership regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic action, input logic [3:0] slot,
                           input logic signed [15:0] px, input logic [15:0] py,
                           input logic signed [15:0] sx);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      gap++;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_action      <= action;
    in_point_index <= slot;
    in_point_x     <= px;
    in_point_y     <= py;
    in_sample_x    <= sx;
    do @(posedge clk); while (busy);
    if (action == ACT_LOAD) slot_x[slot] = px;
    items_sent++;
  endtask

  task automatic load_point(input int slot, input int x, input int y);
    send_item(ACT_LOAD, 4'(slot), 16'(x), 16'(y), 16'($urandom));
  endtask

  task automatic evaluate(input int x);
    send_item(ACT_EVAL, 4'($urandom), 16'($urandom), 16'($urandom), 16'(x));
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_memberships.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_point_count(input int value);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_point_count <= CNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int random_y();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 65535;
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  function automatic int pick_sample();
    int j, lo_x, hi_x;
    j    = $urandom_range(15);
    lo_x = slot_x[j];
    hi_x = (j < 15) ? int'(slot_x[j+1]) : lo_x;
    case ($urandom_range(5))
      0:       return lo_x;
      1:       return lo_x + 1;
      2:       return lo_x - 1;
      3:       return (hi_x > lo_x) ? lo_x + int'($urandom_range(hi_x - lo_x)) : lo_x;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic load_sorted_table(input int n);
    int xs [$];
    int mode, base, v, i;
    mode = $urandom_range(3);
    base = int'($urandom_range(65535)) - 32768;
    for (i = 0; i < n; i++) begin
      case (mode)
        0:       v = int'($urandom_range(65535)) - 32768;
        1:       v = base + int'($urandom_range(300));
        2:       v = (i == 0) ? -32768 : (i == n - 1) ? 32767
                   : int'($urandom_range(65535)) - 32768;
        default: v = base + 4 * int'($urandom_range(3));
      endcase
      if (v > 32767) v = 32767;
      xs = {xs, v};
    end
    xs.sort();
    for (i = 0; i < n; i++) load_point(i, xs[i], random_y());
  endtask

  initial begin
    int p, n, r, phase_start, i;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_LOAD;
    in_point_index  = '0;
    in_point_x      = '0;
    in_point_y      = '0;
    in_sample_x     = '0;
    cfg_valid       = 1'b0;
    cfg_point_count = '0;
    idle_pct        = 0;
    items_sent      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    evaluate(1234);
    for (i = 0; i < 16; i++) load_point(i, directed_x[i], directed_y[i]);
    drain_and_settle();
    write_point_count(16);
    evaluate(-32768);
    evaluate(32767);
    evaluate(0);
    evaluate(-15000);
    evaluate(-25000);
    evaluate(50);
    evaluate(-500);
    evaluate(31000);

    for (p = 0; p < PHASES; p++) begin
      drain_and_settle();
      write_point_count(phase_counts[p]);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        default: idle_pct = 12;
      endcase
      n = (phase_counts[p] > 16) ? 16 : phase_counts[p];
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        r = $urandom_range(9);
        if (r <= 5) begin
          load_sorted_table(n);
          repeat ($urandom_range(12, 4)) evaluate(pick_sample());
        end else if (r <= 7) begin
          repeat ($urandom_range(3, 1))
            load_point($urandom_range(15), int'($urandom_range(65535)), random_y());
          repeat ($urandom_range(6, 2)) evaluate(pick_sample());
        end else begin
          repeat ($urandom_range(10, 3)) evaluate(pick_sample());
        end
      end
    end

    drain_and_settle();
    if (sb.mismatches == 0) begin
      $display("piecewise_linear_membership regression: pass");
    end else begin
      $display("piecewise_linear_membership regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/plm_pkg.sv
hdl/plm_cell.sv
hdl/plm_div.sv
hdl/piecewise_linear_membership.sv
dv/piecewise_linear_membership_test.sv
